// ===== hw/rtl/dph_pkg.sv =====
// Shared types, constants and the residue letter lookup for the dipeptide pair histogram.
package dph_pkg;

    localparam int ALPHABET_SIZE_DEF = 20;
    localparam int COUNT_BITS_DEF    = 16;

    localparam int TABLE_LETTERS = 20;
    localparam int CODE_W        = 5;   // holds any code for an alphabet of up to 32
    localparam int INDEX_W       = 9;
    localparam int RESIDUE_W     = 8;
    localparam int OUT_BITS      = 16;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // tuser bit positions on the input side
    localparam int TUSER_OPCODE = 0;
    localparam int TUSER_FIRST  = 1;

    localparam logic OP_RESIDUE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // reciprocal multiply for pair_index / ALPHABET_SIZE
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;

    localparam logic [TABLE_LETTERS-1:0][RESIDUE_W-1:0] LETTERS = {
        8'h56, 8'h59, 8'h57, 8'h54, 8'h53, 8'h50, 8'h46, 8'h4D, 8'h4B, 8'h4C,
        8'h49, 8'h48, 8'h47, 8'h45, 8'h51, 8'h43, 8'h44, 8'h4E, 8'h52, 8'h41
    };  // index 0 = 'A' ... index 19 = 'V'

    typedef struct packed {
        logic              ok;
        logic [CODE_W-1:0] code;
    } code_t;

    typedef struct packed {
        logic                valid;
        logic                is_read;
        logic                inc;
        logic                clear;
        logic                in_range;
        logic [CODE_W-1:0]   row;
        logic [CODE_W-1:0]   col;
        logic [OUT_BITS-1:0] total;
    } req_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] pairs_counted;
        logic [OUT_BITS-1:0] pair_count;
    } result_t;

    function automatic code_t letter_code(input logic [RESIDUE_W-1:0] ch, input int alphabet);
        code_t res;
        res = '0;
        for (int k = 0; k < TABLE_LETTERS; k++) begin
            if (k < alphabet && !res.ok && ch == LETTERS[k]) begin
                res.ok   = 1'b1;
                res.code = CODE_W'(k);
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/dph_stage1.sv =====
// Input register, residue chain state, pair total and histogram addressing.
module dph_stage1 #(
    parameter int ALPHABET_SIZE = dph_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNT_BITS    = dph_pkg::COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [dph_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [dph_pkg::S_TUSER_W-1:0]     s_tuser,
    output dph_pkg::req_t                     req
);
    localparam int ROW_W     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int BIN_COUNT = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam logic [dph_pkg::RECIP_W-1:0] RECIP =
        dph_pkg::RECIP_W'((2 ** dph_pkg::RECIP_SHIFT + ALPHABET_SIZE - 1) / ALPHABET_SIZE);
    localparam int PROD_W = dph_pkg::INDEX_W + dph_pkg::RECIP_W;

    logic [dph_pkg::RESIDUE_W-1:0] in_residue;
    logic [dph_pkg::INDEX_W-1:0]   in_index;
    dph_pkg::code_t                in_code;
    logic [PROD_W-1:0]             in_prod;

    logic                          s1_valid_reg;
    logic                          s1_read_reg;
    logic                          s1_first_reg;
    dph_pkg::code_t                s1_code_reg;
    logic [dph_pkg::INDEX_W-1:0]   s1_index_reg;
    logic [ROW_W-1:0]              s1_row_reg;
    logic                          s1_range_reg;

    logic [ROW_W-1:0]              prev_code_reg, prev_code_next;
    logic                          prev_valid_reg, prev_valid_next;
    logic [COUNT_BITS-1:0]         total_reg, total_next;

    logic                          is_res, clear, inc;
    logic [ROW_W-1:0]              row;
    logic [ROW_W-1:0]              col;
    logic [dph_pkg::INDEX_W-1:0]   rd_col;
    logic [dph_pkg::OUT_BITS-1:0]  total_out;

    assign in_residue = s_tdata[dph_pkg::RESIDUE_W-1:0];
    assign in_index   = s_tdata[dph_pkg::RESIDUE_W +: dph_pkg::INDEX_W];
    assign in_code    = dph_pkg::letter_code(in_residue, ALPHABET_SIZE);
    assign in_prod    = PROD_W'(in_index) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_read_reg  <= s_tuser[dph_pkg::TUSER_OPCODE];
            s1_first_reg <= s_tuser[dph_pkg::TUSER_FIRST];
            s1_code_reg  <= in_code;
            s1_index_reg <= in_index;
            s1_row_reg   <= in_prod[dph_pkg::RECIP_SHIFT +: ROW_W];
            s1_range_reg <= 32'(in_index) < BIN_COUNT;
        end
    end

    always_comb begin
        is_res = s1_valid_reg && (s1_read_reg == dph_pkg::OP_RESIDUE);
        clear  = is_res && s1_first_reg;
        // a first residue never pairs with what came before it
        inc    = is_res && s1_code_reg.ok && prev_valid_reg && !s1_first_reg;
        rd_col = s1_index_reg - dph_pkg::INDEX_W'(int'(s1_row_reg) * ALPHABET_SIZE);
        row    = inc ? prev_code_reg : (s1_range_reg ? s1_row_reg : '0);
        col    = inc ? s1_code_reg.code[ROW_W-1:0] : rd_col[ROW_W-1:0];
    end

    always_comb begin
        prev_code_next  = prev_code_reg;
        prev_valid_next = prev_valid_reg;
        total_next      = total_reg;
        if (is_res) begin
            prev_valid_next = s1_code_reg.ok;
            if (s1_code_reg.ok) begin
                prev_code_next = s1_code_reg.code[ROW_W-1:0];
            end
        end
        if (clear) begin
            total_next = '0;
        end else if (inc && total_reg != '1) begin
            total_next = total_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_code_reg  <= '0;
            prev_valid_reg <= 1'b0;
            total_reg      <= '0;
        end else begin
            prev_code_reg  <= prev_code_next;
            prev_valid_reg <= prev_valid_next;
            total_reg      <= total_next;
        end
    end

    generate
        if (COUNT_BITS > dph_pkg::OUT_BITS) begin : g_clamp
            assign total_out = (|total_reg[COUNT_BITS-1:dph_pkg::OUT_BITS]) ?
                               '1 : total_reg[dph_pkg::OUT_BITS-1:0];
        end else begin : g_ext
            assign total_out = dph_pkg::OUT_BITS'(total_reg);
        end
    endgenerate

    always_comb begin
        req          = '0;
        req.valid    = s1_valid_reg;
        req.is_read  = s1_valid_reg && (s1_read_reg == dph_pkg::OP_READ);
        req.inc      = inc;
        req.clear    = clear;
        req.in_range = s1_range_reg;
        req.row      = dph_pkg::CODE_W'(row);
        req.col      = dph_pkg::CODE_W'(col);
        req.total    = total_out;
    end

endmodule

// ===== hw/rtl/dph_hist.sv =====
// Histogram row memory with row valid bits, saturating bin update and read result.
module dph_hist #(
    parameter int ALPHABET_SIZE = dph_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNT_BITS    = dph_pkg::COUNT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dph_pkg::req_t     req,
    output logic              push,
    output dph_pkg::result_t  result
);
    localparam int ROW_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    typedef logic [ALPHABET_SIZE-1:0][COUNT_BITS-1:0] word_t;

    // one row of bins per word; a row whose valid bit is low reads as zero
    word_t                    mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] row_valid_reg, row_valid_next;

    logic                     s2_valid_reg;
    logic                     s2_read_reg;
    logic                     s2_inc_reg;
    logic                     s2_range_reg;
    logic [ROW_W-1:0]         s2_row_reg;
    logic [ROW_W-1:0]         s2_col_reg;
    logic [dph_pkg::OUT_BITS-1:0] s2_total_reg;
    word_t                    rd_word_reg;
    logic                     rd_rv_reg;

    logic [ROW_W-1:0]         req_row;
    logic                     wr_en;
    logic                     hit;
    word_t                    word;
    word_t                    new_word;
    logic [COUNT_BITS-1:0]    entry;
    logic [COUNT_BITS-1:0]    entry_inc;
    logic [dph_pkg::OUT_BITS-1:0] entry_out;

    assign req_row = req.row[ROW_W-1:0];
    assign wr_en   = s2_valid_reg && s2_inc_reg;
    // same row written by the beat ahead: take the fresh word instead of memory
    assign hit     = wr_en && (s2_row_reg == req_row);

    always_comb begin
        word      = rd_rv_reg ? rd_word_reg : '0;
        entry     = word[s2_col_reg];
        entry_inc = (entry == '1) ? entry : entry + 1'b1;
        for (int l = 0; l < ALPHABET_SIZE; l++) begin
            new_word[l] = (ROW_W'(l) == s2_col_reg) ? entry_inc : word[l];
        end
    end

    always_comb begin
        row_valid_next = row_valid_reg;
        if (wr_en) begin
            row_valid_next[s2_row_reg] = 1'b1;
        end
        // a clear is younger than the write in flight, so it wins
        if (req.clear) begin
            row_valid_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            s2_valid_reg  <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
            s2_valid_reg  <= req.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s2_row_reg] <= new_word;
        end
        rd_word_reg  <= hit ? new_word : mem[req_row];
        rd_rv_reg    <= hit || row_valid_reg[req_row];
        s2_read_reg  <= req.is_read;
        s2_inc_reg   <= req.inc;
        s2_range_reg <= req.in_range;
        s2_row_reg   <= req_row;
        s2_col_reg   <= req.col[ROW_W-1:0];
        s2_total_reg <= req.total;
    end

    generate
        if (COUNT_BITS > dph_pkg::OUT_BITS) begin : g_clamp
            assign entry_out = (|entry[COUNT_BITS-1:dph_pkg::OUT_BITS]) ?
                               '1 : entry[dph_pkg::OUT_BITS-1:0];
        end else begin : g_ext
            assign entry_out = dph_pkg::OUT_BITS'(entry);
        end
    endgenerate

    assign push = s2_valid_reg && s2_read_reg;

    always_comb begin
        result.pair_count    = s2_range_reg ? entry_out : '0;
        result.pairs_counted = s2_total_reg;
    end

    a_wr_row: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> int'(s2_row_reg) < ALPHABET_SIZE)
        else $error("bin update addresses a row past the alphabet");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        req.valid && req.clear |=> row_valid_reg == '0)
        else $error("histogram rows still valid after a sequence start");

    a_inc_write: assert property (@(posedge aclk) disable iff (!aresetn)
        req.inc |=> wr_en && !push)
        else $error("pair increment did not reach the row write");

endmodule

// ===== hw/rtl/dph_fifo.sv =====
// Result queue between the histogram pipeline and the output channel.
module dph_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  dph_pkg::result_t                  push_data,
    output logic [dph_pkg::FIFO_CNT_W-1:0]    count,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dph_pkg::M_TDATA_W-1:0]     m_tdata
);
    dph_pkg::result_t                   buf_q [dph_pkg::FIFO_DEPTH];
    logic [dph_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dph_pkg::FIFO_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dph_pkg::FIFO_CNT_W-1:0]     count_reg, count_next;
    logic                               pop;

    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = buf_q[rd_ptr_reg];
    assign count    = count_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_q[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> int'(count_reg) < dph_pkg::FIFO_DEPTH)
        else $error("result queue overflow");

endmodule

// ===== hw/rtl/dipeptide_pair_histogram.sv =====
// Top level of the dipeptide pair histogram.
//
//  channel  dir  tdata                                tuser
//  s_       in   [7:0] residue, [16:8] pair_index     [0] opcode, [1] first_of_sequence
//  m_       out  [15:0] pair_count, [31:16] pairs_counted  -
//
//  One beat per cycle on the input while s_tready is high, residue or read alike.
//  A read reaches m_tvalid through the input register, the row memory read
//  register and the result queue.
//  The histogram row read-modify-write is forwarded between adjacent beats.
//  Reset (aresetn low, synchronous) clears all counts, the chain state and the queue.
//  s_tready drops only when the 4-entry result queue plus reads in flight is full.
module dipeptide_pair_histogram #(
    parameter int ALPHABET_SIZE = dph_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNT_BITS    = dph_pkg::COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dph_pkg::S_TDATA_W-1:0]  s_tdata,   // residue, pair_index
    input  logic [dph_pkg::S_TUSER_W-1:0]  s_tuser,   // opcode, first_of_sequence
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dph_pkg::M_TDATA_W-1:0]  m_tdata    // pair_count, pairs_counted
);
    dph_pkg::req_t                    req;
    dph_pkg::result_t                 result;
    logic                             push;
    logic                             accept;
    logic [dph_pkg::FIFO_CNT_W-1:0]   fifo_count;
    logic [dph_pkg::FIFO_CNT_W:0]     pending;

    // queue slots already promised to reads in the pipeline
    assign pending  = (dph_pkg::FIFO_CNT_W + 1)'(fifo_count)
                    + (dph_pkg::FIFO_CNT_W + 1)'(req.is_read)
                    + (dph_pkg::FIFO_CNT_W + 1)'(push);
    assign s_tready = int'(pending) < dph_pkg::FIFO_DEPTH;
    assign accept   = s_tvalid && s_tready;

    dph_stage1 #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .COUNT_BITS    (COUNT_BITS)
    ) u_stage1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .req     (req)
    );

    dph_hist #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .COUNT_BITS    (COUNT_BITS)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .push    (push),
        .result  (result)
    );

    dph_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (result),
        .count     (fifo_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
